// ===== rtl/sirdu_pkg.sv =====
// Package for the signed integer to radix digits unit.
// Shared constants, register index codes and the digit array control struct.
// No dependencies.
package sirdu_pkg;

	localparam int MAG_W     = 32;              // magnitude width of the input
	localparam int NUM_CELLS = 32;              // enough digit cells for radix two
	localparam int CNT_W     = $clog2(MAG_W);
	localparam int RADIX_W   = 5;
	localparam int CHAR_W    = 8;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int BYTES_PER_REG = CFG_W / CHAR_W;

	localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(MAG_W - 1);
	localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'd127;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIX_LENGTH = 2'd0,
		REG_DIGITS_LOW   = 2'd1,
		REG_DIGITS_HIGH  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic clear;   // zero all cells
		logic shift;   // double and add bit_in
		logic bit_in;  // next magnitude bit, MSB first
	} array_ctrl_t;

endpackage

// ===== rtl/sirdu_table_check.sv =====
// Digit table validation for the radix digits unit.
// Checks radix range, printable bytes, sign characters and duplicates.
// Depends on sirdu_pkg.
module sirdu_table_check
	import sirdu_pkg::*;
#(
	parameter int MAX_BASE = 16
) (
	input  logic [RADIX_W-1:0]               radix_len,
	input  logic [MAX_BASE-1:0][CHAR_W-1:0] tbl,
	output logic                             valid
);

	logic len_ok;
	logic bad_char;
	logic dup;

	assign len_ok = (radix_len >= MIN_RADIX) && (radix_len <= RADIX_W'(MAX_BASE));

	always_comb begin
		bad_char = 1'b0;
		dup      = 1'b0;
		for (int a = 0; a < MAX_BASE; a++) begin
			if (RADIX_W'(a) < radix_len) begin
				// bytes at 128 and above fail the unsigned check against DEL
				if (tbl[a] <= CHAR_SPACE || tbl[a] >= CHAR_DEL ||
				    tbl[a] == CHAR_PLUS || tbl[a] == CHAR_MINUS)
					bad_char = 1'b1;
				for (int b = a + 1; b < MAX_BASE; b++) begin
					if (RADIX_W'(b) < radix_len && tbl[b] == tbl[a])
						dup = 1'b1;
				end
			end
		end
	end

	assign valid = len_ok && !bad_char && !dup;

endmodule

// ===== rtl/sirdu_digit_array.sv =====
// Radix digit cell array: the magnitude enters one bit a cycle, MSB first,
// and each cell doubles its digit in the configured radix. Depends on sirdu_pkg.
module sirdu_digit_array
	import sirdu_pkg::*;
#(
	parameter int DIGIT_W = 4
) (
	input  logic                               clk,
	input  array_ctrl_t                        ctrl,
	input  logic [DIGIT_W:0]                   radix,
	output logic [NUM_CELLS-1:0][DIGIT_W-1:0]  digits
);

	logic [NUM_CELLS-1:0][DIGIT_W-1:0] cell_q;
	logic [NUM_CELLS-1:0]              gen;
	logic [NUM_CELLS-1:0]              prop;
	logic [NUM_CELLS:0]                csum;
	logic [NUM_CELLS-1:0]              carry;

	// A cell always carries when 2v >= radix, and carries on a carry in
	// only when 2v + 1 == radix. The chain is resolved by one wide add.
	always_comb begin
		for (int i = 0; i < NUM_CELLS; i++) begin
			gen[i]  = {cell_q[i], 1'b0} >= radix;
			prop[i] = {cell_q[i], 1'b1} == radix;
		end
	end

	assign csum  = {1'b0, gen | prop} + {1'b0, gen} + {{NUM_CELLS{1'b0}}, ctrl.bit_in};
	assign carry = csum[NUM_CELLS-1:0] ^ prop;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			cell_q <= '0;
		end else if (ctrl.shift) begin
			for (int i = 0; i < NUM_CELLS; i++) begin
				if ({cell_q[i], carry[i]} >= radix)
					cell_q[i] <= DIGIT_W'({cell_q[i], carry[i]} - radix);
				else
					cell_q[i] <= DIGIT_W'({cell_q[i], carry[i]});
			end
		end
	end

	assign digits = cell_q;

endmodule

// ===== rtl/signed_integer_to_radix_digits_unit.sv =====
// Signed integer to radix text, most significant digit first.
// Top level: configuration registers, sequencer and output register.
// Depends on sirdu_pkg, sirdu_table_check and sirdu_digit_array.
//
//  channel   direction  handshake              payload
//  input     in         start, busy            number
//  result    out        strobe (one cycle)     out_char, last_char
//  config    in         cfg_we                 cfg_index, cfg_data
//
// An item runs from acceptance until busy drops, D being the digit count:
// S_CONV shifts the magnitude through the digit cell array, S_FIND locates the
// top digit, then S_EMIT gives one character per cycle, D characters in all.
// A '-' appears in the first conversion cycle.
// An item against an invalid table is taken and dropped at once.
// Reset clears the registers, so the table is invalid until configured.
// Results cannot be held off; busy low means the next item is taken.
module signed_integer_to_radix_digits_unit
	import sirdu_pkg::*;
#(
	parameter int MAX_BASE = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [MAG_W-1:0] number,
	output logic                    strobe,
	output logic [CHAR_W-1:0]       out_char,
	output logic                    last_char,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int DIGIT_W = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONV,
		S_FIND,
		S_EMIT
	} state_t;

	state_t                              state_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic [CNT_W-1:0]                    ptr_q;
	logic                                strobe_q;
	logic                                last_q;
	logic [CHAR_W-1:0]                   out_char_q;
	logic [MAG_W-1:0]                    mag_q;
	logic [RADIX_W-1:0]                  radix_q;
	logic [MAX_BASE-1:0][CHAR_W-1:0]     tbl_q;

	logic                                tbl_valid;
	logic                                accept;
	logic [MAG_W-1:0]                    abs_num;
	array_ctrl_t                         arr_ctrl;
	logic [NUM_CELLS-1:0][DIGIT_W-1:0]   digits;
	logic [CNT_W-1:0]                    top_idx;
	logic [DIGIT_W-1:0]                  rd_digit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
			tbl_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RADIX_LENGTH: radix_q <= cfg_data[RADIX_W-1:0];
				REG_DIGITS_LOW: begin
					for (int i = 0; i < MAX_BASE; i++)
						if (i < BYTES_PER_REG)
							tbl_q[i] <= cfg_data[CHAR_W*(i%BYTES_PER_REG) +: CHAR_W];
				end
				REG_DIGITS_HIGH: begin
					for (int i = 0; i < MAX_BASE; i++)
						if (i >= BYTES_PER_REG)
							tbl_q[i] <= cfg_data[CHAR_W*(i%BYTES_PER_REG) +: CHAR_W];
				end
				default: ;
			endcase
		end
	end

	sirdu_table_check #(
		.MAX_BASE (MAX_BASE)
	) u_check (
		.radix_len (radix_q),
		.tbl       (tbl_q),
		.valid     (tbl_valid)
	);

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign abs_num = number[MAG_W-1] ? (~$unsigned(number) + 1'b1) : $unsigned(number);

	// magnitude shift register, MSB leaves first
	always_ff @(posedge clk) begin
		if (accept)
			mag_q <= abs_num;
		else if (state_q == S_CONV)
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
	end

	assign arr_ctrl.clear  = accept;
	assign arr_ctrl.shift  = (state_q == S_CONV);
	assign arr_ctrl.bit_in = mag_q[MAG_W-1];

	sirdu_digit_array #(
		.DIGIT_W (DIGIT_W)
	) u_array (
		.clk    (clk),
		.ctrl   (arr_ctrl),
		.radix  (radix_q[DIGIT_W:0]),
		.digits (digits)
	);

	// highest nonzero cell; zero leaves the pointer on cell 0
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NUM_CELLS; i++)
			if (digits[i] != '0)
				top_idx = CNT_W'(i);
	end

	assign rd_digit = digits[ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			ptr_q      <= '0;
			strobe_q   <= 1'b0;
			last_q     <= 1'b0;
			out_char_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					strobe_q <= start && tbl_valid && number[MAG_W-1];
					last_q   <= 1'b0;
					if (start && tbl_valid) begin
						state_q <= S_CONV;
						cnt_q   <= '0;
						if (number[MAG_W-1])
							out_char_q <= CHAR_MINUS;
					end
				end
				S_CONV: begin
					strobe_q <= 1'b0;
					last_q   <= 1'b0;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= S_FIND;
				end
				S_FIND: begin
					strobe_q <= 1'b0;
					last_q   <= 1'b0;
					ptr_q    <= top_idx;
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					strobe_q   <= 1'b1;
					out_char_q <= tbl_q[rd_digit];
					last_q     <= (ptr_q == '0);
					if (ptr_q == '0)
						state_q <= S_IDLE;
					else
						ptr_q <= ptr_q - 1'b1;
				end
				default: begin
					strobe_q <= 1'b0;
					last_q   <= 1'b0;
					state_q  <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

	// a transaction against a bad table leaves nothing behind
	a_invalid_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !tbl_valid |=> !busy && !strobe)
		else $error("item with invalid table started work");

	a_valid_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tbl_valid |=> busy && state_q == S_CONV && cnt_q == '0)
		else $error("valid item did not start conversion");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && ptr_q == '0 |=> state_q == S_IDLE && strobe && last_char)
		else $error("final digit not marked or block still busy");

	// a table never holds '-', so it can only be the sign
	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !$past(accept) |-> out_char != CHAR_MINUS)
		else $error("minus sign outside the first character");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for signed_integer_to_radix_digits_unit: directed and random numbers
// checked character by character against a predictor of the radix text.
// Depends on sirdu_pkg and the unit under test.
`timescale 1ns / 100ps

module tb_top;
	import sirdu_pkg::*;

	localparam int LIMIT_BASE   = 16;
	localparam int SETTLE_CYC   = 70;     // longer than the slowest item (radix two)
	localparam int DRAIN_BOUND  = 5000;
	localparam int RANDOM_ITEMS = 430;
	localparam int QUIET_FROM   = 380;    // no idling after this many random items
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [MAG_W-1:0] number;
	logic                    strobe;
	logic [CHAR_W-1:0]       out_char;
	logic                    last_char;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;

	// predictor copy of the registers
	logic [RADIX_W-1:0] radix_copy;
	logic [CFG_W-1:0]   digits_low_copy;
	logic [CFG_W-1:0]   digits_high_copy;

	logic [CHAR_W-1:0] digit_set [16];
	text_char_t        pending_text [$];
	int                fault_count;
	bit                idle_enabled;

	signed_integer_to_radix_digits_unit #(
		.MAX_BASE(LIMIT_BASE)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.number    (number),
		.strobe    (strobe),
		.out_char  (out_char),
		.last_char (last_char),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_fault(string msg);
		fault_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic logic [CHAR_W-1:0] table_char(int pos);
		pos = pos & 15;
		if (pos < 8)
			return digits_low_copy[8*pos +: 8];
		return digits_high_copy[8*(pos-8) +: 8];
	endfunction

	function automatic bit table_valid();
		int len;
		logic [CHAR_W-1:0] c;
		len = int'(radix_copy);
		if (len < 2 || len > LIMIT_BASE)
			return 0;
		for (int a = 0; a < len; a++) begin
			c = table_char(a);
			if (c <= CHAR_SPACE || c >= CHAR_DEL || c == CHAR_PLUS || c == CHAR_MINUS)
				return 0;
			for (int b = a + 1; b < len; b++)
				if (table_char(b) == c)
					return 0;
		end
		return 1;
	endfunction

	function automatic void predict_radix_text(logic [MAG_W-1:0] raw);
		logic [MAG_W-1:0]  mag;
		logic [MAG_W-1:0]  radix;
		logic [CHAR_W-1:0] digs [32];
		int                nd;
		logic              neg;
		if (!table_valid())
			return;
		neg   = raw[MAG_W-1];
		mag   = neg ? (32'd0 - raw) : raw;
		radix = MAG_W'(radix_copy);
		nd    = 0;
		do begin
			digs[nd] = table_char(int'(mag % radix));
			nd++;
			mag = mag / radix;
		end while (mag != 0 && nd < 32);
		if (neg)
			pending_text.push_back('{ch: CHAR_MINUS, last: 1'b0});
		for (int k = nd - 1; k >= 0; k--)
			pending_text.push_back('{ch: digs[k], last: (k == 0)});
	endfunction

	// result checker
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && strobe) begin
			if (pending_text.size() == 0) begin
				report_fault($sformatf("unexpected char 0x%02h last=%0b", out_char, last_char));
			end else begin
				want = pending_text.pop_front();
				if (out_char !== want.ch)
					report_fault($sformatf("out_char 0x%02h, want 0x%02h", out_char, want.ch));
				if (last_char !== want.last)
					report_fault($sformatf("last_char %0b, want %0b", last_char, want.last));
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_RADIX_LENGTH: radix_copy       = data[RADIX_W-1:0];
			REG_DIGITS_LOW:   digits_low_copy  = data;
			REG_DIGITS_HIGH:  digits_high_copy = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// radix written with random upper bits, which the register drops
	task automatic load_table(int len);
		logic [CFG_W-1:0] lo, hi, rl;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = digit_set[i];
			hi[8*i +: 8] = digit_set[i+8];
		end
		rl = {$urandom, $urandom};
		rl[RADIX_W-1:0] = RADIX_W'(len);
		write_reg(REG_RADIX_LENGTH, rl);
		write_reg(REG_DIGITS_LOW, lo);
		write_reg(REG_DIGITS_HIGH, hi);
	endtask

	task automatic set_digits(string s);
		for (int i = 0; i < 16; i++)
			digit_set[i] = (i < s.len()) ? CHAR_W'(s[i]) : 8'h00;
	endtask

	task automatic fill_valid_table(int len);
		bit used [256];
		int c;
		for (int i = 0; i < 16; i++) begin
			if (i < len) begin
				do c = $urandom_range(33, 126);
				while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
				used[c] = 1;
				digit_set[i] = CHAR_W'(c);
			end else begin
				digit_set[i] = CHAR_W'($urandom_range(0, 255));
			end
		end
	endtask

	function automatic logic [CHAR_W-1:0] bad_byte();
		case ($urandom_range(0, 4))
			0: return CHAR_W'($urandom_range(0, 32));
			1: return CHAR_DEL;
			2: return CHAR_W'($urandom_range(128, 255));
			3: return CHAR_PLUS;
			default: return CHAR_MINUS;
		endcase
	endfunction

	task automatic send_number(logic [MAG_W-1:0] value);
		@(negedge clk);
		start  <= 1'b1;
		number <= value;
		do @(posedge clk);
		while (busy);
		predict_radix_text(value);
	endtask

	task automatic idle_gap();
		int r;
		if (!idle_enabled)
			return;
		r = $urandom_range(0, 9);
		if (r < 3) begin
			@(negedge clk);
			start <= 1'b0;
			if (r == 0) begin
				do @(posedge clk);
				while (busy);
			end
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	endtask

	// block idle: all text in, then a pause for items that give no text
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		start <= 1'b0;
		while (pending_text.size() != 0 && waited < DRAIN_BOUND) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYC) @(posedge clk);
		if (pending_text.size() != 0) begin
			report_fault($sformatf("%0d chars never arrived", pending_text.size()));
			pending_text.delete();
		end
	endtask

	task automatic test_reset_table();
		send_number(32'd0);
		send_number(-32'sd5);
		settle();
	endtask

	task automatic test_decimal();
		set_digits("0123456789");
		load_table(10);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		write_reg(REG_RADIX_LENGTH, 64'hFFFF_FFFF_FFFF_FFEA);
		send_number(32'd0);
		send_number(32'd7);
		send_number(-32'sd7);
		send_number(32'h7FFF_FFFF);
		send_number(32'h8000_0000);
		send_number(32'd1_000_000_000);
		settle();
	endtask

	task automatic test_binary();
		set_digits("01");
		load_table(2);
		send_number(32'h8000_0000);
		send_number(32'h7FFF_FFFF);
		send_number(32'hFFFF_FFFF);
		settle();
	endtask

	task automatic test_hex_edge_chars();
		set_digits("!0123456789abcd~");
		load_table(16);
		send_number(32'hDEAD_BEEF);
		send_number(32'h0000_FFFF);
		settle();
	endtask

	task automatic test_unused_bytes();
		set_digits("xyz");
		digit_set[4]  = CHAR_MINUS;
		digit_set[12] = 8'hFF;
		load_table(3);
		send_number(32'd8);
		send_number(-32'sd9);
		settle();
	endtask

	task automatic test_bad_tables();
		int lens [4] = '{0, 1, 17, 31};
		logic [CHAR_W-1:0] bads [5] = '{CHAR_SPACE, CHAR_DEL, 8'h80, CHAR_PLUS, CHAR_MINUS};
		set_digits("!0123456789abcd~");
		foreach (lens[i]) begin
			load_table(lens[i]);
			send_number(32'd12345);
			settle();
		end
		foreach (bads[i]) begin
			set_digits("0123456789");
			digit_set[3] = bads[i];
			load_table(10);
			send_number(-32'sd42);
			settle();
		end
		set_digits("0123456789");
		digit_set[9] = "2";
		load_table(10);
		send_number(32'd99);
		settle();
	endtask

	task automatic make_invalid_table();
		int len, a, b;
		case ($urandom_range(0, 4))
			0: begin
				fill_valid_table(16);
				len = $urandom_range(0, 1);
			end
			1: begin
				fill_valid_table(16);
				len = $urandom_range(17, 31);
			end
			2: begin
				len = $urandom_range(2, 16);
				fill_valid_table(len);
				digit_set[$urandom_range(0, len - 1)] = bad_byte();
			end
			3: begin
				len = $urandom_range(2, 16);
				fill_valid_table(len);
				a = $urandom_range(0, len - 1);
				do b = $urandom_range(0, len - 1);
				while (b == a);
				digit_set[b] = digit_set[a];
			end
			default: begin
				len = $urandom_range(0, 31);
				foreach (digit_set[i])
					digit_set[i] = CHAR_W'($urandom_range(0, 255));
			end
		endcase
		load_table(len);
	endtask

	function automatic int pick_radix();
		case ($urandom_range(0, 3))
			0: return 2;
			1: return 16;
			default: return $urandom_range(2, 16);
		endcase
	endfunction

	function automatic logic [MAG_W-1:0] pick_number();
		longint p;
		int k;
		logic [MAG_W-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: v = 32'd0;
					1: v = 32'd1;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h7FFF_FFFF;
					default: v = 32'h8000_0000;
				endcase
			end
			1, 2: begin
				v = $urandom_range(0, 300);
				if ($urandom_range(0, 1))
					v = 32'd0 - v;
			end
			3: begin
				// around a power of the radix, where the digit count steps
				p = 1;
				k = $urandom_range(1, 31);
				while (radix_copy >= 2 && k > 0 &&
				       p * longint'(radix_copy) <= 64'h8000_0000) begin
					p = p * longint'(radix_copy);
					k--;
				end
				v = MAG_W'(p - $urandom_range(0, 1));
				if ($urandom_range(0, 1))
					v = 32'd0 - v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic test_random_conversions();
		int count, len, phase_items;
		count = 0;
		while (count < RANDOM_ITEMS) begin
			idle_enabled = (count < QUIET_FROM);
			settle();
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_UNUSED, {$urandom, $urandom});
			if ($urandom_range(0, 6) == 0) begin
				make_invalid_table();
			end else begin
				len = pick_radix();
				fill_valid_table(len);
				load_table(len);
			end
			phase_items = table_valid() ? $urandom_range(15, 40) : $urandom_range(2, 5);
			repeat (phase_items) begin
				idle_gap();
				send_number(pick_number());
				if (table_valid())
					count++;
			end
		end
		settle();
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		number       = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		radix_copy       = '0;
		digits_low_copy  = '0;
		digits_high_copy = '0;
		fault_count  = 0;
		idle_enabled = 1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_table();
		test_decimal();
		test_binary();
		test_hex_edge_chars();
		test_unused_bytes();
		test_bad_tables();
		test_random_conversions();

		if (fault_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sirdu_pkg.sv
rtl/sirdu_table_check.sv
rtl/sirdu_digit_array.sv
rtl/signed_integer_to_radix_digits_unit.sv
tb/sv/tb_top.sv
